// ----- rtl/ack_retransmit_tracker_assert.svh -----
// Assertion macros for the retransmit tracker.
// Expects signals named clk and rst_n in the scope of each use.
`ifndef ACK_RETRANSMIT_TRACKER_ASSERT_SVH
`define ACK_RETRANSMIT_TRACKER_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define ART_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("art assertion failed");

// Consequent must hold in the cycle after the antecedent.
`define ART_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("art assertion failed");

`endif

// ----- rtl/art_pkg.sv -----
// Shared types and constants for the retransmit tracker.
// No dependencies; used by every other file of the block but the assertion header.
`timescale 1ns / 1ps
`default_nettype none

package art_pkg;

    localparam int FUNC_W      = 2;
    localparam int ID_W        = 32;
    localparam int STAMP_W     = 32;
    localparam int TIMEOUT_W   = 16;
    localparam int RETRY_W     = 3;
    localparam int SLOT_W      = 4;
    localparam int STATUS_W    = 3;
    localparam int CFG_INDEX_W = 4;
    localparam int CFG_DATA_W  = 16;

    localparam int QUEUE_DEPTH = 2;
    localparam int QUEUE_PTR_W = 1;
    localparam int QUEUE_CNT_W = 2;

    // Input function codes
    localparam logic [FUNC_W-1:0] FUNC_SEND = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_ACK  = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_TICK = 2'd2;

    // Result status codes
    localparam logic [STATUS_W-1:0] ST_STORED        = 3'd0;
    localparam logic [STATUS_W-1:0] ST_TABLE_FULL    = 3'd1;
    localparam logic [STATUS_W-1:0] ST_ACKED         = 3'd2;
    localparam logic [STATUS_W-1:0] ST_ACK_UNMATCHED = 3'd3;
    localparam logic [STATUS_W-1:0] ST_RETRY         = 3'd4;
    localparam logic [STATUS_W-1:0] ST_GAVE_UP       = 3'd5;
    localparam logic [STATUS_W-1:0] ST_TICK_DONE     = 3'd6;

    // Configuration register indexes and reset values
    localparam logic [CFG_INDEX_W-1:0] CFG_TIMEOUT_TICKS = 4'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_RETRY_LIMIT   = 4'd1;
    localparam logic [TIMEOUT_W-1:0]   TIMEOUT_RESET     = 16'd5;
    localparam logic [RETRY_W-1:0]     RETRY_RESET       = 3'd3;

    typedef enum logic [1:0] {
        CMD_SEND,
        CMD_ACK,
        CMD_TICK,
        CMD_ACK_NULL
    } cmd_kind_t;

    typedef struct packed {
        cmd_kind_t         kind;
        logic [ID_W-1:0]   ack_id;
        logic              link_up;
    } cmd_t;

    typedef struct packed {
        logic valid;
        cmd_t cmd;
    } queue_head_t;

    typedef struct packed {
        logic [TIMEOUT_W-1:0] timeout_ticks;
        logic [RETRY_W-1:0]   retry_limit;
    } cfg_t;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [ID_W-1:0]     msg_id;
        logic [SLOT_W-1:0]   slot;
        logic                last;
    } rsp_t;

endpackage

`default_nettype wire

// ----- rtl/art_ifs.sv -----
// Channel interfaces of the retransmit tracker: request, result, configuration.
// Depends on art_pkg for field widths.
`timescale 1ns / 1ps
`default_nettype none

interface art_req_if;
    logic                        valid;
    logic                        ready;
    logic [art_pkg::FUNC_W-1:0]  func;
    logic [art_pkg::ID_W-1:0]    ack_id;
    logic                        link_up;

    modport source (output valid, output func, output ack_id, output link_up, input ready);
    modport sink   (input valid, input func, input ack_id, input link_up, output ready);
endinterface

interface art_rsp_if;
    logic                          valid;
    logic                          ready;
    logic [art_pkg::STATUS_W-1:0]  status;
    logic [art_pkg::ID_W-1:0]      msg_id;
    logic [art_pkg::SLOT_W-1:0]    slot;
    logic                          last;

    modport source (output valid, output status, output msg_id, output slot, output last,
                    input ready);
    modport sink   (input valid, input status, input msg_id, input slot, input last,
                    output ready);
endinterface

interface art_cfg_if;
    logic                             valid;
    logic                             ready;
    logic [art_pkg::CFG_INDEX_W-1:0]  index;
    logic [art_pkg::CFG_DATA_W-1:0]   data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

// ----- rtl/art_front.sv -----
// Front end: accepts requests and classifies them into queue commands.
// Depends on art_pkg and art_req_if.
`timescale 1ns / 1ps
`default_nettype none

module art_front (
    art_req_if.sink         req,
    output logic            push_valid,
    output art_pkg::cmd_t   push_cmd,
    input  logic            push_ready
);

    always_comb
    begin
        push_valid      = 1'b0;
        push_cmd.ack_id = req.ack_id;
        push_cmd.link_up = req.link_up;
        push_cmd.kind   = art_pkg::CMD_TICK;
        unique case (req.func)
            art_pkg::FUNC_SEND:
            begin
                push_valid    = req.valid;
                push_cmd.kind = art_pkg::CMD_SEND;
            end
            art_pkg::FUNC_ACK:
            begin
                push_valid = req.valid;
                // a zero identifier never matches: answer without a scan
                push_cmd.kind = (req.ack_id == '0) ? art_pkg::CMD_ACK_NULL
                                                   : art_pkg::CMD_ACK;
            end
            art_pkg::FUNC_TICK:
            begin
                push_valid    = req.valid;
                push_cmd.kind = art_pkg::CMD_TICK;
            end
            default:
            begin
                // unused code: accept and drop
                push_valid = 1'b0;
            end
        endcase
    end

    assign req.ready = push_ready;

endmodule

`default_nettype wire

// ----- rtl/art_cmd_queue.sv -----
// Short command queue between the front end and the slot engine.
// Depends on art_pkg and the assertion macro header.
`timescale 1ns / 1ps
`default_nettype none

`include "ack_retransmit_tracker_assert.svh"

module art_cmd_queue (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 push_valid,
    input  art_pkg::cmd_t        push_cmd,
    output logic                 push_ready,
    output art_pkg::queue_head_t head,
    input  logic                 pop
);

    art_pkg::cmd_t                     entry_reg [art_pkg::QUEUE_DEPTH];
    logic [art_pkg::QUEUE_PTR_W-1:0]   wr_ptr_reg;
    logic [art_pkg::QUEUE_PTR_W-1:0]   wr_ptr_next;
    logic [art_pkg::QUEUE_PTR_W-1:0]   rd_ptr_reg;
    logic [art_pkg::QUEUE_PTR_W-1:0]   rd_ptr_next;
    logic [art_pkg::QUEUE_CNT_W-1:0]   count_reg;
    logic [art_pkg::QUEUE_CNT_W-1:0]   count_next;
    logic                              push_en;
    logic                              pop_en;

    assign push_ready = (count_reg != art_pkg::QUEUE_CNT_W'(art_pkg::QUEUE_DEPTH));
    assign push_en    = push_valid && push_ready;
    assign pop_en     = pop && (count_reg != '0);

    assign head.valid = (count_reg != '0);
    assign head.cmd   = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push_en ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop_en ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (push_en && !pop_en)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop_en && !push_en)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push_en)
        begin
            entry_reg[wr_ptr_reg] <= push_cmd;
        end
    end

    `ART_ASSERT_NOW(a_empty_ptrs_meet, count_reg == '0, wr_ptr_reg == rd_ptr_reg)

endmodule

`default_nettype wire

// ----- rtl/art_engine.sv -----
// Back end: runs queued commands, scanning one slot a cycle unless rsp stalls.
// Depends on art_pkg, art_rsp_if and the assertion macro header.
`timescale 1ns / 1ps
`default_nettype none

`include "ack_retransmit_tracker_assert.svh"

module art_engine #(
    parameter int SLOT_COUNT = 16
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  art_pkg::cfg_t         cfg,
    input  art_pkg::queue_head_t  head,
    output logic                  pop,
    art_rsp_if.source             rsp
);

    localparam int IDX_W = $clog2(SLOT_COUNT);

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_EVAL  = 2'd1;
    localparam logic [1:0] S_FINAL = 2'd2;

    // slot table: identifier, send stamp, retry count
    logic [art_pkg::ID_W-1:0]    ident_mem   [SLOT_COUNT];
    logic [art_pkg::STAMP_W-1:0] stamp_mem   [SLOT_COUNT];
    logic [art_pkg::RETRY_W-1:0] retries_mem [SLOT_COUNT];
    logic [art_pkg::ID_W-1:0]    ident_q_reg;
    logic [art_pkg::STAMP_W-1:0] stamp_q_reg;
    logic [art_pkg::RETRY_W-1:0] retries_q_reg;

    logic [SLOT_COUNT-1:0]       valid_reg;
    logic [1:0]                  state_reg;
    logic [1:0]                  state_next;
    logic [IDX_W-1:0]            idx_reg;
    logic [IDX_W-1:0]            idx_next;
    logic [art_pkg::ID_W-1:0]    next_ident_reg;
    logic [art_pkg::ID_W-1:0]    next_ident_next;
    logic [art_pkg::STAMP_W-1:0] now_reg;
    logic [art_pkg::STAMP_W-1:0] now_next;
    logic                        rsp_valid_reg;

    art_pkg::cmd_t               cmd_reg;
    art_pkg::cmd_t               cmd_next;
    logic [art_pkg::ID_W-1:0]    id_reg;
    logic [art_pkg::ID_W-1:0]    id_next;
    logic [art_pkg::STATUS_W-1:0] fin_status_reg;
    logic [art_pkg::STATUS_W-1:0] fin_status_next;
    logic [art_pkg::ID_W-1:0]    fin_id_reg;
    logic [art_pkg::ID_W-1:0]    fin_id_next;
    art_pkg::rsp_t               rsp_data_reg;
    art_pkg::rsp_t               rsp_next;

    logic                        rd_en;
    logic [IDX_W-1:0]            rd_addr;
    logic                        wr_ident_en;
    logic                        wr_stamp_en;
    logic [art_pkg::STAMP_W-1:0] wr_stamp_data;
    logic                        wr_retries_en;
    logic [art_pkg::RETRY_W-1:0] wr_retries_data;
    logic                        set_valid;
    logic                        clr_valid;
    logic                        emit;
    logic                        emit_stored;
    logic                        can_emit;
    logic                        last_slot;
    logic                        occupied;
    logic [art_pkg::STAMP_W-1:0] elapsed;
    logic                        expired;
    logic                        retry_ok;
    logic                        need_emit;
    logic                        done_on_emit;
    logic [art_pkg::ID_W-1:0]    ident_bump;

    assign can_emit   = !rsp_valid_reg || rsp.ready;
    assign last_slot  = (idx_reg == IDX_W'(SLOT_COUNT - 1));
    assign occupied   = valid_reg[idx_reg];
    assign elapsed    = now_reg - stamp_q_reg;
    assign expired    = occupied && (elapsed >= art_pkg::STAMP_W'(cfg.timeout_ticks));
    assign retry_ok   = (retries_q_reg < cfg.retry_limit);
    assign ident_bump = next_ident_reg + 1'b1;

    always_comb
    begin
        state_next      = state_reg;
        idx_next        = idx_reg;
        next_ident_next = next_ident_reg;
        now_next        = now_reg;
        cmd_next        = cmd_reg;
        id_next         = id_reg;
        fin_status_next = fin_status_reg;
        fin_id_next     = fin_id_reg;
        pop             = 1'b0;
        rd_en           = 1'b0;
        rd_addr         = idx_reg + 1'b1;
        wr_ident_en     = 1'b0;
        wr_stamp_en     = 1'b0;
        wr_stamp_data   = now_reg;
        wr_retries_en   = 1'b0;
        wr_retries_data = '0;
        set_valid       = 1'b0;
        clr_valid       = 1'b0;
        emit            = 1'b0;
        need_emit       = 1'b0;
        done_on_emit    = 1'b0;
        rsp_next.status = art_pkg::ST_TICK_DONE;
        rsp_next.msg_id = '0;
        rsp_next.slot   = art_pkg::SLOT_W'(idx_reg);
        rsp_next.last   = 1'b0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (head.valid)
                begin
                    pop      = 1'b1;
                    cmd_next = head.cmd;
                    if (head.cmd.kind == art_pkg::CMD_ACK_NULL)
                    begin
                        fin_status_next = art_pkg::ST_ACK_UNMATCHED;
                        fin_id_next     = head.cmd.ack_id;
                        state_next      = S_FINAL;
                    end
                    else
                    begin
                        rd_en      = 1'b1;
                        rd_addr    = '0;
                        idx_next   = '0;
                        state_next = S_EVAL;
                    end
                    if (head.cmd.kind == art_pkg::CMD_SEND)
                    begin
                        // identifier is consumed even if the table turns out full
                        id_next         = next_ident_reg;
                        next_ident_next = (ident_bump == '0) ? art_pkg::ID_W'(1) : ident_bump;
                    end
                    if (head.cmd.kind == art_pkg::CMD_TICK)
                    begin
                        now_next = now_reg + 1'b1;
                    end
                end
            end

            S_EVAL:
            begin
                case (cmd_reg.kind)
                    art_pkg::CMD_SEND:
                    begin
                        need_emit       = !occupied;
                        done_on_emit    = 1'b1;
                        rsp_next.status = art_pkg::ST_STORED;
                        rsp_next.msg_id = id_reg;
                        rsp_next.last   = 1'b1;
                        wr_ident_en     = need_emit && can_emit;
                        wr_stamp_en     = need_emit && can_emit;
                        wr_retries_en   = need_emit && can_emit;
                        set_valid       = need_emit && can_emit;
                    end
                    art_pkg::CMD_ACK:
                    begin
                        need_emit       = occupied && (ident_q_reg == cmd_reg.ack_id);
                        done_on_emit    = 1'b1;
                        rsp_next.status = art_pkg::ST_ACKED;
                        rsp_next.msg_id = cmd_reg.ack_id;
                        rsp_next.last   = 1'b1;
                        clr_valid       = need_emit && can_emit;
                    end
                    default:
                    begin
                        rsp_next.msg_id = ident_q_reg;
                        if (expired && retry_ok)
                        begin
                            // link down: leave the slot as it is, no result
                            need_emit       = cmd_reg.link_up;
                            rsp_next.status = art_pkg::ST_RETRY;
                            wr_stamp_en     = need_emit && can_emit;
                            wr_retries_en   = need_emit && can_emit;
                            wr_retries_data = retries_q_reg + 1'b1;
                        end
                        else if (expired)
                        begin
                            need_emit       = 1'b1;
                            rsp_next.status = art_pkg::ST_GAVE_UP;
                            clr_valid       = can_emit;
                        end
                    end
                endcase

                if (!need_emit || can_emit)
                begin
                    emit = need_emit;
                    if (need_emit && done_on_emit)
                    begin
                        state_next = S_IDLE;
                    end
                    else if (last_slot)
                    begin
                        state_next = S_FINAL;
                        case (cmd_reg.kind)
                            art_pkg::CMD_SEND:
                            begin
                                fin_status_next = art_pkg::ST_TABLE_FULL;
                                fin_id_next     = id_reg;
                            end
                            art_pkg::CMD_ACK:
                            begin
                                fin_status_next = art_pkg::ST_ACK_UNMATCHED;
                                fin_id_next     = cmd_reg.ack_id;
                            end
                            default:
                            begin
                                fin_status_next = art_pkg::ST_TICK_DONE;
                                fin_id_next     = '0;
                            end
                        endcase
                    end
                    else
                    begin
                        // advance: fetch the next slot while this one is written back
                        rd_en    = 1'b1;
                        idx_next = idx_reg + 1'b1;
                    end
                end
            end

            S_FINAL:
            begin
                rsp_next.status = fin_status_reg;
                rsp_next.msg_id = fin_id_reg;
                rsp_next.slot   = '0;
                rsp_next.last   = 1'b1;
                if (can_emit)
                begin
                    emit       = 1'b1;
                    state_next = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign emit_stored = emit && (state_reg == S_EVAL) && (cmd_reg.kind == art_pkg::CMD_SEND);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            idx_reg        <= '0;
            next_ident_reg <= art_pkg::ID_W'(1);
            now_reg        <= '0;
            valid_reg      <= '0;
            rsp_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            idx_reg        <= idx_next;
            next_ident_reg <= next_ident_next;
            now_reg        <= now_next;
            if (set_valid)
            begin
                valid_reg[idx_reg] <= 1'b1;
            end
            if (clr_valid)
            begin
                valid_reg[idx_reg] <= 1'b0;
            end
            if (emit)
            begin
                rsp_valid_reg <= 1'b1;
            end
            else if (rsp.ready)
            begin
                rsp_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg        <= cmd_next;
        id_reg         <= id_next;
        fin_status_reg <= fin_status_next;
        fin_id_reg     <= fin_id_next;
        if (emit)
        begin
            rsp_data_reg <= rsp_next;
        end
    end

    // slot table memories: one registered read and one write a cycle
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            ident_q_reg   <= ident_mem[rd_addr];
            stamp_q_reg   <= stamp_mem[rd_addr];
            retries_q_reg <= retries_mem[rd_addr];
        end
        if (wr_ident_en)
        begin
            ident_mem[idx_reg] <= id_reg;
        end
        if (wr_stamp_en)
        begin
            stamp_mem[idx_reg] <= wr_stamp_data;
        end
        if (wr_retries_en)
        begin
            retries_mem[idx_reg] <= wr_retries_data;
        end
    end

    assign rsp.valid  = rsp_valid_reg;
    assign rsp.status = rsp_data_reg.status;
    assign rsp.msg_id = rsp_data_reg.msg_id;
    assign rsp.slot   = rsp_data_reg.slot;
    assign rsp.last   = rsp_data_reg.last;

    `ART_ASSERT_NOW(a_ident_nonzero, 1'b1, next_ident_reg != '0)
    `ART_ASSERT_NEXT(a_stored_sets_valid, emit_stored, valid_reg[$past(idx_reg)])
    `ART_ASSERT_NOW(a_pop_only_idle, pop, state_reg == S_IDLE)

endmodule

`default_nettype wire

// ----- rtl/ack_retransmit_tracker.sv -----
// Top level of the acknowledgment retransmit tracker: configuration registers
// and the front end, command queue and slot engine. Depends on art_pkg and art_ifs.
//
// Usage:
//   req : requests (func, ack_id, link_up), taken on valid && ready. func send
//         stores a new identifier, ack frees a matching slot, tick advances time
//         and checks every slot for expiry; the unused func code is dropped.
//   rsp : results (status, msg_id, slot, last) from an output register; last
//         marks the final result of a request. A tick gives one result per
//         retried or dropped slot and then a tick-done result.
//   cfg : register writes (index, data), always ready; write only while idle.
// Flow: a request is registered in the command queue, then the engine walks the
//   slot table one entry a cycle through its memory read port while rsp does not
//   stall. A send or ack ends at the first hit; a full scan ends with a closing
//   result. The engine takes the next request only after the last one is done.
//   An ack naming identifier zero is answered without a scan.
// Reset: all slots empty, next identifier one, time zero, timeout 5, retry
//   limit 3. When rsp stalls, the engine holds at the pending result and the
//   queue keeps taking requests until its two entries are full.
`timescale 1ns / 1ps
`default_nettype none

module ack_retransmit_tracker #(
    parameter int SLOT_COUNT = 16
) (
    input  logic        clk,
    input  logic        rst_n,
    art_req_if.sink     req,
    art_rsp_if.source   rsp,
    art_cfg_if.sink     cfg
);

    logic [art_pkg::TIMEOUT_W-1:0] timeout_reg;
    logic [art_pkg::RETRY_W-1:0]   retry_limit_reg;
    art_pkg::cfg_t                 cfg_vals;
    logic                          push_valid;
    logic                          push_ready;
    art_pkg::cmd_t                 push_cmd;
    art_pkg::queue_head_t          head;
    logic                          pop;

    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            timeout_reg     <= art_pkg::TIMEOUT_RESET;
            retry_limit_reg <= art_pkg::RETRY_RESET;
        end
        else if (cfg.valid)
        begin
            unique case (cfg.index)
                art_pkg::CFG_TIMEOUT_TICKS:
                begin
                    timeout_reg <= cfg.data[art_pkg::TIMEOUT_W-1:0];
                end
                art_pkg::CFG_RETRY_LIMIT:
                begin
                    retry_limit_reg <= cfg.data[art_pkg::RETRY_W-1:0];
                end
                default:
                begin
                    // unknown index: drop the write
                end
            endcase
        end
    end

    assign cfg_vals.timeout_ticks = timeout_reg;
    assign cfg_vals.retry_limit   = retry_limit_reg;

    art_front u_front (
        .req        (req),
        .push_valid (push_valid),
        .push_cmd   (push_cmd),
        .push_ready (push_ready)
    );

    art_cmd_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_cmd   (push_cmd),
        .push_ready (push_ready),
        .head       (head),
        .pop        (pop)
    );

    art_engine #(
        .SLOT_COUNT (SLOT_COUNT)
    ) u_engine (
        .clk   (clk),
        .rst_n (rst_n),
        .cfg   (cfg_vals),
        .head  (head),
        .pop   (pop),
        .rsp   (rsp)
    );

endmodule

`default_nettype wire

// ----- tb/sv/art_result_checker.sv -----
`timescale 1ns / 1ps
// Result checker for the retransmit tracker: tracks the slot table from accepted
// requests and register writes, and compares every accepted result in order.
// Depends on art_pkg and the channel interfaces in art_ifs.
module art_result_checker #(
    parameter int SLOT_COUNT = 16
) (
    input  logic clk,
    input  logic rst_n,
    art_req_if   req,
    art_rsp_if   rsp,
    art_cfg_if   cfg,
    output int   expected_left,
    output int   mismatch_count
);

    art_pkg::rsp_t                   pending_results[$];
    logic [art_pkg::ID_W-1:0]        table_ident   [SLOT_COUNT];
    logic [art_pkg::STAMP_W-1:0]     table_stamp   [SLOT_COUNT];
    logic [art_pkg::RETRY_W-1:0]     table_retries [SLOT_COUNT];
    logic [art_pkg::ID_W-1:0]        ident_counter;
    logic [art_pkg::STAMP_W-1:0]     tick_count;
    logic [art_pkg::TIMEOUT_W-1:0]   cur_timeout;
    logic [art_pkg::RETRY_W-1:0]     cur_retry_limit;
    int                              errors = 0;

    function automatic void push_result(logic [art_pkg::STATUS_W-1:0] st,
                                        logic [art_pkg::ID_W-1:0] id,
                                        int s, logic fin);
        art_pkg::rsp_t r;
        r.status = st;
        r.msg_id = id;
        r.slot   = art_pkg::SLOT_W'(s);
        r.last   = fin;
        pending_results.push_back(r);
    endfunction

    function automatic void check_field(string field, logic [31:0] want, logic [31:0] got);
        if (want !== got)
        begin
            $display("%0t: %s mismatch, expected %0h, got %0h", $time, field, want, got);
            errors++;
        end
    endfunction

    // Update the slot table for one request and queue the results it gives.
    function automatic void apply_request(logic [art_pkg::FUNC_W-1:0] f,
                                          logic [art_pkg::ID_W-1:0] id,
                                          logic lu);
        logic [art_pkg::ID_W-1:0]    given;
        logic [art_pkg::STAMP_W-1:0] elapsed;
        int                          hit;
        int                          i;
        hit = -1;
        case (f)
            art_pkg::FUNC_SEND:
            begin
                given = ident_counter;
                ident_counter = ident_counter + 1;
                if (ident_counter == '0)
                    ident_counter = 1;
                for (i = 0; i < SLOT_COUNT; i++)
                    if (hit < 0 && table_ident[i] == '0)
                        hit = i;
                if (hit < 0)
                    push_result(art_pkg::ST_TABLE_FULL, given, 0, 1'b1);
                else
                begin
                    table_ident[hit]   = given;
                    table_stamp[hit]   = tick_count;
                    table_retries[hit] = '0;
                    push_result(art_pkg::ST_STORED, given, hit, 1'b1);
                end
            end
            art_pkg::FUNC_ACK:
            begin
                if (id != '0)
                    for (i = 0; i < SLOT_COUNT; i++)
                        if (hit < 0 && table_ident[i] == id)
                            hit = i;
                if (hit < 0)
                    push_result(art_pkg::ST_ACK_UNMATCHED, id, 0, 1'b1);
                else
                begin
                    table_ident[hit] = '0;
                    push_result(art_pkg::ST_ACKED, id, hit, 1'b1);
                end
            end
            art_pkg::FUNC_TICK:
            begin
                tick_count = tick_count + 1;
                for (i = 0; i < SLOT_COUNT; i++)
                begin
                    if (table_ident[i] != '0)
                    begin
                        elapsed = tick_count - table_stamp[i];
                        if (elapsed >= art_pkg::STAMP_W'(cur_timeout))
                        begin
                            if (table_retries[i] < cur_retry_limit)
                            begin
                                // hold the slot untouched while the link is down
                                if (lu)
                                begin
                                    table_stamp[i]   = tick_count;
                                    table_retries[i] = table_retries[i] + 1'b1;
                                    push_result(art_pkg::ST_RETRY, table_ident[i], i, 1'b0);
                                end
                            end
                            else
                            begin
                                push_result(art_pkg::ST_GAVE_UP, table_ident[i], i, 1'b0);
                                table_ident[i] = '0;
                            end
                        end
                    end
                end
                push_result(art_pkg::ST_TICK_DONE, '0, 0, 1'b1);
            end
            default: ;
        endcase
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        art_pkg::rsp_t got;
        art_pkg::rsp_t want;
        if (!rst_n)
        begin
            for (int i = 0; i < SLOT_COUNT; i++)
            begin
                table_ident[i]   = '0;
                table_stamp[i]   = '0;
                table_retries[i] = '0;
            end
            ident_counter   = 1;
            tick_count      = '0;
            cur_timeout     = art_pkg::TIMEOUT_RESET;
            cur_retry_limit = art_pkg::RETRY_RESET;
            pending_results.delete();
        end
        else
        begin
            if (cfg.valid && cfg.ready)
            begin
                case (cfg.index)
                    art_pkg::CFG_TIMEOUT_TICKS:
                        cur_timeout = cfg.data[art_pkg::TIMEOUT_W-1:0];
                    art_pkg::CFG_RETRY_LIMIT:
                        cur_retry_limit = cfg.data[art_pkg::RETRY_W-1:0];
                    default: ;
                endcase
            end
            if (rsp.valid && rsp.ready)
            begin
                got.status = rsp.status;
                got.msg_id = rsp.msg_id;
                got.slot   = rsp.slot;
                got.last   = rsp.last;
                if (pending_results.size() == 0)
                begin
                    $display("%0t: unexpected result, expected none, got status %0d id %0h",
                             $time, got.status, got.msg_id);
                    errors++;
                end
                else
                begin
                    want = pending_results.pop_front();
                    check_field("status", 32'(want.status), 32'(got.status));
                    check_field("msg_id", want.msg_id, got.msg_id);
                    check_field("slot", 32'(want.slot), 32'(got.slot));
                    check_field("last", 32'(want.last), 32'(got.last));
                end
            end
            if (req.valid && req.ready)
                apply_request(req.func, req.ack_id, req.link_up);
        end
        expected_left  <= pending_results.size();
        mismatch_count <= errors;
    end

endmodule

// ----- tb/sv/testbench.sv -----
`timescale 1ns / 1ps
// Top of the retransmit tracker regression: clock, reset, request and register
// stimulus, random result back-pressure and the verdict.
// Depends on art_pkg, art_ifs, the tracker RTL and art_result_checker.
module testbench;

    localparam int SLOT_COUNT   = 16;
    localparam int DRAIN_CYCLES = 3 * SLOT_COUNT;
    localparam int CYCLE_LIMIT  = 1000000;
    localparam logic [art_pkg::FUNC_W-1:0] FUNC_UNUSED = 2'd3;

    logic clk;
    logic rst_n;
    int   expected_left;
    int   mismatch_count;
    int   src_idle_pct = 36;
    int   snk_idle_pct = 57;
    int   cycle_count  = 0;

    // up to the last 24 identifiers handed out, newest last, to aim acknowledgments at
    logic [art_pkg::ID_W-1:0] sent_ids[$];
    logic [art_pkg::ID_W-1:0] ident_next = 1;

    art_req_if req();
    art_rsp_if rsp();
    art_cfg_if cfg();

    ack_retransmit_tracker #(.SLOT_COUNT(SLOT_COUNT)) dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req),
        .rsp   (rsp),
        .cfg   (cfg)
    );

    art_result_checker #(.SLOT_COUNT(SLOT_COUNT)) u_result_checker (
        .clk            (clk),
        .rst_n          (rst_n),
        .req            (req),
        .rsp            (rsp),
        .cfg            (cfg),
        .expected_left  (expected_left),
        .mismatch_count (mismatch_count)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    always @(posedge clk)
        rsp.ready <= ($urandom_range(0, 99) >= snk_idle_pct);

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    task automatic put_request(input logic [art_pkg::FUNC_W-1:0] f,
                               input logic [art_pkg::ID_W-1:0] id,
                               input logic lu);
        while ($urandom_range(0, 99) < src_idle_pct)
        begin
            req.valid <= 1'b0;
            @(posedge clk);
        end
        req.valid   <= 1'b1;
        req.func    <= f;
        req.ack_id  <= id;
        req.link_up <= lu;
        do @(posedge clk); while (!req.ready);
        if (f == art_pkg::FUNC_SEND)
        begin
            sent_ids.push_back(ident_next);
            if (sent_ids.size() > 24)
                void'(sent_ids.pop_front());
            ident_next = ident_next + 1;
            if (ident_next == '0)
                ident_next = 1;
        end
    endtask

    // Drop valid and hold until every result is in, then let the engine go quiet.
    task automatic settle();
        req.valid <= 1'b0;
        do @(posedge clk); while (expected_left != 0);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [art_pkg::CFG_INDEX_W-1:0] idx,
                             input logic [art_pkg::CFG_DATA_W-1:0] value);
        cfg.valid <= 1'b1;
        cfg.index <= idx;
        cfg.data  <= value;
        do @(posedge clk); while (!cfg.ready);
        cfg.valid <= 1'b0;
        @(posedge clk);
    endtask

    task automatic run_phase(input int items, input logic [art_pkg::TIMEOUT_W-1:0] tmo,
                             input logic [art_pkg::RETRY_W-1:0] lim);
        int done;
        int pick;
        logic [art_pkg::ID_W-1:0] target;
        settle();
        write_reg(art_pkg::CFG_TIMEOUT_TICKS, art_pkg::CFG_DATA_W'(tmo));
        write_reg(art_pkg::CFG_RETRY_LIMIT, art_pkg::CFG_DATA_W'(lim));
        done = 0;
        while (done < items)
        begin
            pick = $urandom_range(0, 99);
            if (sent_ids.size() == 0)
                target = $urandom;
            else
                target = sent_ids[$urandom_range(0, sent_ids.size() - 1)];
            if (pick < 40)
                put_request(art_pkg::FUNC_SEND, $urandom, $urandom_range(0, 99) < 85);
            else if (pick < 68)
                put_request(art_pkg::FUNC_ACK, target, 1'($urandom_range(0, 1)));
            else if (pick < 92)
                put_request(art_pkg::FUNC_TICK, $urandom, $urandom_range(0, 99) < 80);
            else if (pick < 95)
                put_request(art_pkg::FUNC_ACK, $urandom, 1'($urandom_range(0, 1)));
            else if (pick < 97)
                put_request(art_pkg::FUNC_ACK, '0, 1'($urandom_range(0, 1)));
            else
                put_request(FUNC_UNUSED, $urandom, 1'($urandom_range(0, 1)));
            if (pick < 97)
                done++;
            if ($urandom_range(0, 99) < 2)
                settle();
        end
    endtask

    initial
    begin
        rst_n       = 1'b0;
        req.valid   = 1'b0;
        req.func    = art_pkg::FUNC_SEND;
        req.ack_id  = '0;
        req.link_up = 1'b0;
        rsp.ready   = 1'b0;
        cfg.valid   = 1'b0;
        cfg.index   = art_pkg::CFG_TIMEOUT_TICKS;
        cfg.data    = '0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        write_reg(art_pkg::CFG_TIMEOUT_TICKS, 16'd1);
        write_reg(art_pkg::CFG_RETRY_LIMIT, 16'd1);
        put_request(art_pkg::FUNC_ACK, '0, 1'b1);
        put_request(art_pkg::FUNC_ACK, '1, 1'b0);
        put_request(FUNC_UNUSED, '1, 1'b1);
        // fill every slot, then one more for a full table
        repeat (SLOT_COUNT + 1)
            put_request(art_pkg::FUNC_SEND, $urandom, 1'($urandom_range(0, 1)));
        // identifiers start at one, so slot 4 holds identifier 5
        put_request(art_pkg::FUNC_ACK, 32'd5, 1'b0);
        put_request(art_pkg::FUNC_ACK, 32'd5, 1'b1);
        put_request(art_pkg::FUNC_SEND, '0, 1'b0);
        put_request(art_pkg::FUNC_TICK, '0, 1'b0);
        put_request(art_pkg::FUNC_TICK, '0, 1'b1);
        put_request(art_pkg::FUNC_TICK, '1, 1'b1);

        run_phase(60, 16'd3, 3'd7);
        run_phase(60, 16'd0, 3'd2);
        settle();
        src_idle_pct <= 57;
        snk_idle_pct <= 36;
        run_phase(60, 16'hFFFF, 3'd0);
        run_phase(60, 16'd2, 3'd0);
        settle();
        src_idle_pct <= 0;
        snk_idle_pct <= 0;
        run_phase(60, 16'd1, 3'd5);
        settle();

        if (mismatch_count == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
